// File: sv/mvns_pkg.sv
// Shared types and constants for the MIDI voice note-off scheduler.
// No dependencies; the voice RAM, the core and the testbench import this package.
`default_nettype none

package mvns_pkg;

  localparam logic MODE_EVENT = 1'b0;
  localparam logic MODE_TICK  = 1'b1;

  localparam logic [3:0] NOTE_ON_NIBBLE  = 4'h9;
  localparam logic [3:0] NOTE_OFF_NIBBLE = 4'h8;

  // Note-offs emitted per tick are capped at this many.
  localparam int MAX_RESULTS = 16;
  localparam int EMIT_CNT_W  = $clog2(MAX_RESULTS + 1);

  typedef struct packed {
    logic [15:0] remaining;
    logic [7:0]  note;
    logic [3:0]  channel;
  } voice_t;

  typedef struct packed {
    logic [7:0]  status;
    logic [7:0]  data_one;
    logic [7:0]  data_two;
    logic [15:0] length;
    logic        last;
  } result_t;

endpackage

`default_nettype wire

// File: sv/mvns_in_if.sv
// Input channel of the scheduler: one MIDI event or one tick per beat.
// Valid/ready handshake; no dependencies.
`default_nettype none

interface mvns_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [7:0]  status_byte;
  logic [7:0]  data_one;
  logic [7:0]  data_two;
  logic [15:0] note_length;

  modport source (output valid, mode, status_byte, data_one, data_two, note_length,
                  input ready);
  modport sink   (input valid, mode, status_byte, data_one, data_two, note_length,
                  output ready);
endinterface

`default_nettype wire

// File: sv/mvns_out_if.sv
// Output channel of the scheduler: one forwarded event or note-off per beat.
// Valid/ready handshake; no dependencies.
`default_nettype none

interface mvns_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_status;
  logic [7:0]  out_data_one;
  logic [7:0]  out_data_two;
  logic [15:0] out_length;
  logic        last_of_run;

  modport source (output valid, out_status, out_data_one, out_data_two, out_length,
                  last_of_run, input ready);
  modport sink   (input valid, out_status, out_data_one, out_data_two, out_length,
                  last_of_run, output ready);
endinterface

`default_nettype wire

// File: sv/mvns_voice_ram.sv
// Voice table: one-read, one-write synchronous memory with registered read data.
// Per-entry valid bits make never-written voices read as zero. Uses mvns_pkg.
`default_nettype none

module mvns_voice_ram
  import mvns_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int IDX_W = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_idx,
  output voice_t           rd_data,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_idx,
  input  voice_t           wr_data
);

  voice_t           mem [DEPTH];
  logic [DEPTH-1:0] written;
  voice_t           rd_word;
  logic             rd_written;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    if (rd_en) begin
      rd_word <= mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written    <= '0;
      rd_written <= 1'b0;
    end else begin
      if (wr_en) begin
        written[wr_idx] <= 1'b1;
      end
      if (rd_en) begin
        rd_written <= written[rd_idx];
      end
    end
  end

  assign rd_data = rd_written ? rd_word : '0;

endmodule

`default_nettype wire

// File: sv/midi_voice_noteoff_scheduler_core.sv
// Event forward: the event is held in the pending slot, then loaded into the output
// register once the output is free, and the block returns to idle for the next input
// beat. Note-on and tick: the voice table is scanned one voice per cycle through its
// single read port while no new result is stalled behind the pending slot; a note-on
// stops at the first free voice, and a tick or a dropped note-on scans every voice. Synchronous
// reset returns to idle and marks every voice free at once through the valid bits.
// Uses mvns_pkg, mvns_in_if, mvns_out_if and mvns_voice_ram.
`default_nettype none

module midi_voice_noteoff_scheduler_core
  import mvns_pkg::*;
#(
  parameter int VOICE_COUNT = 16
) (
  input  logic       clk,
  input  logic       rst,
  mvns_in_if.sink    events,
  mvns_out_if.source notes
);

  localparam int IDX_W = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
  localparam int CNT_W = $clog2(VOICE_COUNT + 1);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_FLUSH = 3'b100
  } state_t;

  state_t state;

  logic        it_mode;
  logic [7:0]  it_status;
  logic [7:0]  it_d1;
  logic [7:0]  it_d2;
  logic [15:0] it_len;

  logic [CNT_W-1:0]      rd_idx;
  logic                  ev_vld;
  logic [IDX_W-1:0]      ev_idx;
  logic [EMIT_CNT_W-1:0] emit_cnt;
  logic                  pend_vld;
  result_t               pend;
  logic                  out_vld;
  result_t               out;

  voice_t  ent;
  voice_t  wr_data;
  result_t new_res;
  logic    accept, note_on_in, rd_more, free_hit, expire, emit_now;
  logic    out_busy, stall, adv, issue, wr_en, move_pend, flush_load;

  assign accept     = events.valid && events.ready;
  assign note_on_in = (events.mode == MODE_EVENT)
                   && (events.status_byte[7:4] == NOTE_ON_NIBBLE)
                   && (events.data_two != 8'd0);

  assign rd_more  = rd_idx < CNT_W'(VOICE_COUNT);
  assign free_hit = (state == ST_SCAN) && ev_vld && (it_mode == MODE_EVENT)
                 && (ent.remaining == 16'd0);
  // A nonzero count of one reaches zero on this tick.
  assign expire   = (state == ST_SCAN) && ev_vld && (it_mode == MODE_TICK)
                 && (ent.remaining == 16'd1);
  assign emit_now = free_hit || (expire && (emit_cnt < EMIT_CNT_W'(MAX_RESULTS)));

  assign out_busy = out_vld && !notes.ready;
  // A new result needs the pending slot; the pending one must move out first.
  assign stall    = emit_now && pend_vld && out_busy;
  assign adv      = !ev_vld || !stall;
  assign issue    = (state == ST_SCAN) && rd_more && adv;

  assign wr_en = (state == ST_SCAN) && ev_vld && !stall
              && (free_hit || ((it_mode == MODE_TICK) && (ent.remaining != 16'd0)));

  always_comb begin
    if (free_hit) begin
      wr_data = '{remaining: it_len, note: it_d1, channel: it_status[3:0]};
      new_res = '{status: it_status, data_one: it_d1, data_two: it_d2,
                  length: it_len, last: 1'b0};
    end else begin
      wr_data = '{remaining: ent.remaining - 16'd1, note: ent.note,
                  channel: ent.channel};
      new_res = '{status: {NOTE_OFF_NIBBLE, ent.channel}, data_one: ent.note,
                  data_two: 8'd0, length: 16'd0, last: 1'b0};
    end
  end

  assign move_pend  = emit_now && pend_vld && !out_busy;
  assign flush_load = (state == ST_FLUSH) && pend_vld && !out_busy;

  mvns_voice_ram #(
    .DEPTH (VOICE_COUNT),
    .IDX_W (IDX_W)
  ) u_ram (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (issue),
    .rd_idx  (rd_idx[IDX_W-1:0]),
    .rd_data (ent),
    .wr_en   (wr_en),
    .wr_idx  (ev_idx),
    .wr_data (wr_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      ev_vld   <= 1'b0;
      pend_vld <= 1'b0;
      out_vld  <= 1'b0;
    end else begin
      if (move_pend || flush_load) begin
        out_vld <= 1'b1;
      end else if (notes.ready) begin
        out_vld <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (events.mode == MODE_EVENT && !note_on_in) begin
              pend_vld <= 1'b1;
              state    <= ST_FLUSH;
            end else begin
              ev_vld <= 1'b0;
              state  <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (emit_now && !stall) begin
            pend_vld <= 1'b1;
          end
          if (free_hit) begin
            ev_vld <= 1'b0;
            state  <= ST_FLUSH;
          end else begin
            if (issue) begin
              ev_vld <= 1'b1;
            end else if (adv) begin
              ev_vld <= 1'b0;
            end
            if (!rd_more && !ev_vld) begin
              state <= ST_FLUSH;
            end
          end
        end
        ST_FLUSH: begin
          if (!pend_vld) begin
            state <= ST_IDLE;
          end else if (!out_busy) begin
            pend_vld <= 1'b0;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Payload and scan bookkeeping.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && accept) begin
      it_mode   <= events.mode;
      it_status <= events.status_byte;
      it_d1     <= events.data_one;
      it_d2     <= events.data_two;
      it_len    <= events.note_length;
      rd_idx    <= '0;
      emit_cnt  <= '0;
      pend      <= '{status: events.status_byte, data_one: events.data_one,
                     data_two: events.data_two, length: events.note_length,
                     last: 1'b0};
    end
    if (issue) begin
      ev_idx <= rd_idx[IDX_W-1:0];
      rd_idx <= rd_idx + CNT_W'(1);
    end
    if (expire && emit_now && !stall) begin
      emit_cnt <= emit_cnt + EMIT_CNT_W'(1);
    end
    if (emit_now && !stall) begin
      pend <= new_res;
    end
    if (move_pend) begin
      out <= pend;
    end else if (flush_load) begin
      out <= '{status: pend.status, data_one: pend.data_one, data_two: pend.data_two,
               length: pend.length, last: 1'b1};
    end
  end

  assign events.ready       = (state == ST_IDLE);
  assign notes.valid        = out_vld;
  assign notes.out_status   = out.status;
  assign notes.out_data_one = out.data_one;
  assign notes.out_data_two = out.data_two;
  assign notes.out_length   = out.length;
  assign notes.last_of_run  = out.last;

endmodule

`default_nettype wire

// File: sv/mvns_checker.sv
// Port-level checks for the scheduler, attached to the top level by bind.
// Sees only the top level's ports; no package dependency.
`default_nettype none

module mvns_checker (
  input logic        clk,
  input logic        rst,
  input logic        ev_valid,
  input logic        ev_ready,
  input logic        res_valid,
  input logic        res_ready,
  input logic [7:0]  res_status,
  input logic [7:0]  res_data_two,
  input logic [15:0] res_length,
  input logic        res_last
);

  // A waiting result beat stays offered.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result beat withdrawn before it was taken");

  // The block works on one item at a time.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    ev_valid && ev_ready |=> !ev_ready)
    else $error("input taken while an item is still in work");

  // Only generated note-offs can be followed by more beats of the same item.
  a_mid_run: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_last |->
      res_status[7:4] == 4'h8 && res_data_two == 8'd0 && res_length == 16'd0)
    else $error("non-final beat is not a note-off");

  // A stalled result keeps its status and last flag.
  a_res_stable: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> $stable(res_status) && $stable(res_last))
    else $error("stalled result payload changed");

endmodule

bind midi_voice_noteoff_scheduler_core mvns_checker u_mvns_checker (
  .clk          (clk),
  .rst          (rst),
  .ev_valid     (events.valid),
  .ev_ready     (events.ready),
  .res_valid    (notes.valid),
  .res_ready    (notes.ready),
  .res_status   (notes.out_status),
  .res_data_two (notes.out_data_two),
  .res_length   (notes.out_length),
  .res_last     (notes.last_of_run)
);

`default_nettype wire

// File: dv/midi_voice_noteoff_scheduler_core_tb.sv
// Self-checking testbench for midi_voice_noteoff_scheduler_core: note-on voice claims,
// forwarded events and tick-driven note-offs, checked beat by beat against a local model.
// Depends on mvns_pkg, mvns_in_if, mvns_out_if and the core RTL.
`timescale 1ns / 1ps

module midi_voice_noteoff_scheduler_core_tb
  import mvns_pkg::*;
();

  localparam int VOICES       = 16;
  localparam int RANDOM_ITEMS = 125;
  localparam int CALM_AFTER   = 100;
  localparam int TAIL_CYCLES  = 60;
  localparam int REPORT_LIMIT = 10;

  localparam logic [3:0] CTRL_CHANGE_NIBBLE = 4'hB;
  localparam logic [3:0] PITCH_BEND_NIBBLE  = 4'hE;
  localparam logic [3:0] SYSTEM_NIBBLE      = 4'hF;

  // Rows of the directed script; want_count < 0 leaves the expectation to the model.
  typedef struct {
    logic        mode;
    logic [7:0]  status_byte;
    logic [7:0]  data_one;
    logic [7:0]  data_two;
    logic [15:0] note_length;
    int          want_count;
    result_t     want;
  } script_row_t;

  logic clk = 1'b0;
  logic rst;

  mvns_in_if  events();
  mvns_out_if notes();

  midi_voice_noteoff_scheduler_core dut (
    .clk    (clk),
    .rst    (rst),
    .events (events),
    .notes  (notes)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Local copy of the voice table.
  logic [15:0] hold_ticks [VOICES];
  logic [7:0]  held_note  [VOICES];
  logic [3:0]  held_chan  [VOICES];

  result_t     step_results[$];
  result_t     due_events[$];
  script_row_t script[$];
  int          mismatches = 0;
  int          beats_in = 0;
  bit          calm = 1'b0;

  function automatic void clear_voices();
    for (int v = 0; v < VOICES; v++) begin
      hold_ticks[v] = '0;
      held_note[v]  = '0;
      held_chan[v]  = '0;
    end
  endfunction

  // Works out the beats that one input item causes and updates the voice table.
  function automatic void schedule_step(logic mode, logic [7:0] status_byte,
                                        logic [7:0] data_one, logic [7:0] data_two,
                                        logic [15:0] note_length);
    int      slot;
    int      emitted;
    result_t r;
    step_results.delete();
    if (mode == MODE_EVENT) begin
      if (status_byte[7:4] == NOTE_ON_NIBBLE && data_two != 8'h00) begin
        slot = -1;
        for (int v = 0; v < VOICES; v++)
          if (slot < 0 && hold_ticks[v] == 16'h0000) slot = v;
        // A note-on with every voice busy is dropped without a beat.
        if (slot < 0) return;
        held_note[slot]  = data_one;
        held_chan[slot]  = status_byte[3:0];
        hold_ticks[slot] = note_length;
      end
      step_results.push_back({status_byte, data_one, data_two, note_length, 1'b1});
    end else begin
      emitted = 0;
      for (int v = 0; v < VOICES; v++) begin
        if (hold_ticks[v] != 16'h0000) begin
          hold_ticks[v] = hold_ticks[v] - 16'd1;
          if (hold_ticks[v] == 16'h0000 && emitted < MAX_RESULTS) begin
            step_results.push_back({NOTE_OFF_NIBBLE, held_chan[v], held_note[v],
                                    8'h00, 16'h0000, 1'b0});
            emitted++;
          end
        end
      end
      if (emitted > 0) begin
        r = step_results.pop_back();
        r.last = 1'b1;
        step_results.push_back(r);
      end
    end
  endfunction

  function automatic script_row_t row(logic mode, logic [7:0] status_byte,
                                      logic [7:0] data_one, logic [7:0] data_two,
                                      logic [15:0] note_length, int want_count,
                                      result_t want);
    script_row_t s;
    s.mode        = mode;
    s.status_byte = status_byte;
    s.data_one    = data_one;
    s.data_two    = data_two;
    s.note_length = note_length;
    s.want_count  = want_count;
    s.want        = want;
    return s;
  endfunction

  task automatic send_item(input logic mode, input logic [7:0] status_byte,
                           input logic [7:0] data_one, input logic [7:0] data_two,
                           input logic [15:0] note_length, input int want_count,
                           input result_t want);
    int gap;
    @(negedge clk);
    if (!calm && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 12);
      events.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    events.valid       <= 1'b1;
    events.mode        <= mode;
    events.status_byte <= status_byte;
    events.data_one    <= data_one;
    events.data_two    <= data_two;
    events.note_length <= note_length;
    do @(posedge clk); while (!events.ready);
    beats_in++;
    schedule_step(mode, status_byte, data_one, data_two, note_length);
    if (want_count < 0) begin
      foreach (step_results[i]) due_events.push_back(step_results[i]);
    end else if (want_count > 0) begin
      due_events.push_back(want);
    end
  endtask

  task automatic send_random(input logic mode, input logic [7:0] status_byte,
                             input logic [7:0] data_one, input logic [7:0] data_two,
                             input logic [15:0] note_length);
    send_item(mode, status_byte, data_one, data_two, note_length, -1, '0);
  endtask

  // Output side: stall bursts separated by stretches of steady ready.
  initial begin
    int run;
    notes.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (calm || $urandom_range(0, 3) != 0) begin
        notes.ready <= 1'b1;
        run = $urandom_range(1, 30);
        repeat (run - 1) @(negedge clk);
      end else begin
        notes.ready <= 1'b0;
        run = $urandom_range(1, 12);
        repeat (run - 1) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst && notes.valid && notes.ready) begin
      got = {notes.out_status, notes.out_data_one, notes.out_data_two, notes.out_length,
             notes.last_of_run};
      if (due_events.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("ERROR: unexpected beat status=%h data1=%h data2=%h len=%h last=%b",
                   got.status, got.data_one, got.data_two, got.length, got.last);
      end else begin
        want = due_events.pop_front();
        if (got.status !== want.status || got.data_one !== want.data_one ||
            got.data_two !== want.data_two || got.length !== want.length ||
            got.last !== want.last) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display({"ERROR: beat mismatch exp status=%h data1=%h data2=%h len=%h last=%b",
                      " got status=%h data1=%h data2=%h len=%h last=%b"},
                     want.status, want.data_one, want.data_two, want.length, want.last,
                     got.status, got.data_one, got.data_two, got.length, got.last);
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    int          burst;
    int          ticks;
    int          base_len;
    bit          shared_len;
    bit          drained;
    logic [15:0] len;
    script_row_t s;

    clear_voices();
    drained            = 1'b0;
    rst                = 1'b1;
    events.valid       = 1'b0;
    events.mode        = MODE_EVENT;
    events.status_byte = '0;
    events.data_one    = '0;
    events.data_two    = '0;
    events.note_length = '0;

    // Directed script. Voice 0 ends up held by the longest possible note.
    script.push_back(row(MODE_TICK, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 0, '0));
    script.push_back(row(MODE_EVENT, 8'h00, 8'h00, 8'h00, 16'h0000, 1,
                         {8'h00, 8'h00, 8'h00, 16'h0000, 1'b1}));
    script.push_back(row(MODE_EVENT, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 1,
                         {8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 1'b1}));
    script.push_back(row(MODE_EVENT, {CTRL_CHANGE_NIBBLE, 4'h3}, 8'h07, 8'h64, 16'h0010, 1,
                         {CTRL_CHANGE_NIBBLE, 4'h3, 8'h07, 8'h64, 16'h0010, 1'b1}));
    // Velocity zero is not a note-on: forwarded, and no voice taken.
    script.push_back(row(MODE_EVENT, {NOTE_ON_NIBBLE, 4'h5}, 8'h40, 8'h00, 16'h0005, 1,
                         {NOTE_ON_NIBBLE, 4'h5, 8'h40, 8'h00, 16'h0005, 1'b1}));
    // Zero duration records note and channel but leaves the voice free.
    script.push_back(row(MODE_EVENT, {NOTE_ON_NIBBLE, 4'h2}, 8'h3C, 8'h64, 16'h0000, 1,
                         {NOTE_ON_NIBBLE, 4'h2, 8'h3C, 8'h64, 16'h0000, 1'b1}));
    script.push_back(row(MODE_TICK, 8'h00, 8'h00, 8'h00, 16'h0000, 0, '0));
    script.push_back(row(MODE_EVENT, {NOTE_ON_NIBBLE, 4'h0}, 8'h3C, 8'h7F, 16'h0001, 1,
                         {NOTE_ON_NIBBLE, 4'h0, 8'h3C, 8'h7F, 16'h0001, 1'b1}));
    script.push_back(row(MODE_TICK, 8'h00, 8'h00, 8'h00, 16'h0000, 1,
                         {NOTE_OFF_NIBBLE, 4'h0, 8'h3C, 8'h00, 16'h0000, 1'b1}));
    script.push_back(row(MODE_EVENT, {NOTE_OFF_NIBBLE, 4'h0}, 8'h3C, 8'h40, 16'h0000, 1,
                         {NOTE_OFF_NIBBLE, 4'h0, 8'h3C, 8'h40, 16'h0000, 1'b1}));
    script.push_back(row(MODE_EVENT, {NOTE_ON_NIBBLE, 4'hF}, 8'h7F, 8'h01, 16'h0002, -1, '0));
    script.push_back(row(MODE_EVENT, {NOTE_ON_NIBBLE, 4'hA}, 8'h00, 8'h40, 16'h0002, -1, '0));
    script.push_back(row(MODE_EVENT, {NOTE_ON_NIBBLE, 4'h7}, 8'h55, 8'hFF, 16'h0003, -1, '0));
    script.push_back(row(MODE_TICK, 8'h00, 8'h00, 8'h00, 16'h0000, 0, '0));
    script.push_back(row(MODE_TICK, 8'hA5, 8'h5A, 8'hC3, 16'h3C3C, -1, '0));
    script.push_back(row(MODE_TICK, 8'h00, 8'h00, 8'h00, 16'h0000, -1, '0));
    script.push_back(row(MODE_EVENT, {NOTE_ON_NIBBLE, 4'h1}, 8'h55, 8'h10, 16'hFFFF, 1,
                         {NOTE_ON_NIBBLE, 4'h1, 8'h55, 8'h10, 16'hFFFF, 1'b1}));
    script.push_back(row(MODE_EVENT, {PITCH_BEND_NIBBLE, 4'hC}, 8'h00, 8'h40, 16'h8000, 1,
                         {PITCH_BEND_NIBBLE, 4'hC, 8'h00, 8'h40, 16'h8000, 1'b1}));
    script.push_back(row(MODE_EVENT, {SYSTEM_NIBBLE, 4'h8}, 8'h12, 8'h34, 16'h5678, 1,
                         {SYSTEM_NIBBLE, 4'h8, 8'h12, 8'h34, 16'h5678, 1'b1}));
    script.push_back(row(MODE_TICK, 8'h00, 8'h00, 8'h00, 16'h0000, 0, '0));

    repeat (8) @(negedge clk);
    rst = 1'b0;

    foreach (script[i]) begin
      s = script[i];
      send_item(s.mode, s.status_byte, s.data_one, s.data_two, s.note_length,
                s.want_count, s.want);
    end

    // Random part: mostly chords of note-ons followed by ticks, some noise.
    while (beats_in < script.size() + RANDOM_ITEMS) begin
      calm = (beats_in >= script.size() + CALM_AFTER);
      if (!drained && beats_in >= script.size() + RANDOM_ITEMS / 2) begin
        // Drop valid so the last beat is not taken again while the results drain.
        @(negedge clk);
        events.valid <= 1'b0;
        while (due_events.size() != 0) @(posedge clk);
        drained = 1'b1;
      end
      if ($urandom_range(0, 9) < 7) begin
        burst      = $urandom_range(1, 18);
        shared_len = 1'($urandom_range(0, 1));
        base_len   = $urandom_range(1, 5);
        for (int i = 0; i < burst; i++) begin
          if ($urandom_range(0, 7) == 0)
            send_random(MODE_EVENT, 8'($urandom), 8'($urandom), 8'($urandom),
                        16'($urandom));
          if ($urandom_range(0, 9) == 0)
            send_random(MODE_TICK, 8'($urandom), 8'($urandom), 8'($urandom),
                        16'($urandom));
          if ($urandom_range(0, 29) == 0)
            len = 16'($urandom);
          else if ($urandom_range(0, 19) == 0)
            len = 16'h0000;
          else if (shared_len)
            len = 16'(base_len);
          else
            len = 16'($urandom_range(1, 6));
          send_random(MODE_EVENT, {NOTE_ON_NIBBLE, 4'($urandom)}, 8'($urandom),
                      8'($urandom_range(1, 255)), len);
        end
        ticks = $urandom_range(1, 7);
        repeat (ticks) send_random(MODE_TICK, 8'($urandom), 8'($urandom), 8'($urandom),
                                   16'($urandom));
      end else begin
        repeat ($urandom_range(1, 4))
          send_random(1'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                      16'($urandom));
      end
    end

    @(negedge clk);
    events.valid <= 1'b0;
    while (due_events.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (due_events.size() != 0)
      $display("ERROR: %0d expected beats never arrived", due_events.size());
    if (mismatches == 0 && due_events.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
